>>> hw/rtl/kla_pkg.sv
package kla_pkg;

  localparam int ID_W    = 10;
  localparam int STEPS_W = 20;
  localparam int CMD_W   = 3;

  localparam int DEF_NODE_COUNT = 1024;
  localparam int DEF_LEVELS     = 20;

  localparam int IN_TDATA_W  = 40;
  localparam int IN_TUSER_W  = 8;
  localparam int OUT_TDATA_W = 16;

  localparam int NODE_LSB  = 0;
  localparam int PAR_LSB   = NODE_LSB + ID_W;
  localparam int STEPS_LSB = PAR_LSB + ID_W;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_BUILD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd5;

  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] kla_op_t;

  localparam kla_op_t OP_NOP        = 5'd0;
  localparam kla_op_t OP_CAPTURE    = 5'd1;
  localparam kla_op_t OP_SWEEP      = 5'd2;
  localparam kla_op_t OP_SET_PARENT = 5'd3;
  localparam kla_op_t OP_REMOVE     = 5'd4;
  localparam kla_op_t OP_BLD_INIT   = 5'd5;
  localparam kla_op_t OP_RD_LVL     = 5'd6;
  localparam kla_op_t OP_RD_ROW     = 5'd7;
  localparam kla_op_t OP_RD_Q       = 5'd8;
  localparam kla_op_t OP_RD_TOP     = 5'd9;
  localparam kla_op_t OP_INS_WR     = 5'd10;
  localparam kla_op_t OP_BLD_WR     = 5'd11;
  localparam kla_op_t OP_PRS_RD     = 5'd12;
  localparam kla_op_t OP_Q_ZERO     = 5'd13;
  localparam kla_op_t OP_HI_TAKE    = 5'd14;
  localparam kla_op_t OP_BIT_TAKE   = 5'd15;
  localparam kla_op_t OP_BIT_SKIP   = 5'd16;
  localparam kla_op_t OP_OUT        = 5'd17;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             node_zero;
    logic             sweep_last;
    logic             lvl_last;
    logic             row_last;
    logic             present;
    logic             cur_zero;
    logic             hi_zero;
    logic             lvl_zero;
    logic             bit_set;
    logic             out_busy;
  } kla_stat_t;

endpackage

>>> hw/rtl/kla_ram.sv
module kla_ram #(
  parameter int AW = 4,
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/kla_datapath.sv
module kla_datapath #(
  parameter int NODE_COUNT = 1024,
  parameter int LEVELS     = 20
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  kla_pkg::kla_op_t                 op,
  output kla_pkg::kla_stat_t               stat,
  input  logic [kla_pkg::IN_TUSER_W-1:0]   in_tuser,
  input  logic [kla_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [kla_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import kla_pkg::*;

  localparam int NW  = $clog2(NODE_COUNT);
  localparam int LW  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int AW  = NW + LW;
  localparam int TOP = LEVELS - 1;
  localparam logic [LW-1:0] LVL_TOP  = LW'(TOP);
  localparam logic [NW-1:0] ROW_LAST = NW'(NODE_COUNT - 1);

  logic [CMD_W-1:0]   cmd_r, cmd_nxt;
  logic [ID_W-1:0]    node_r, node_nxt;
  logic [ID_W-1:0]    par_r, par_nxt;
  logic [STEPS_W-1:0] hi_r, hi_nxt;
  logic [STEPS_W-1:0] low_r, low_nxt;
  logic [ID_W-1:0]    cur_r, cur_nxt;
  logic [LW-1:0]      lvl_r, lvl_nxt;
  logic [NW-1:0]      row_r, row_nxt;
  logic [AW-1:0]      sweep_r, sweep_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ID_W-1:0]    out_data_r, out_data_nxt;

  logic               tbl_we;
  logic [AW-1:0]      tbl_waddr;
  logic [ID_W-1:0]    tbl_wdata;
  logic [AW-1:0]      tbl_raddr;
  logic [ID_W-1:0]    tbl_q;
  logic               prs_we;
  logic [NW-1:0]      prs_waddr;
  logic               prs_wdata;
  logic [NW-1:0]      prs_q_idx;
  logic               prs_q;

  logic [NW-1:0]      node_idx;
  logic [NW-1:0]      cur_idx;
  logic [NW-1:0]      q_idx;
  logic [LW-1:0]      lvl_m1;
  logic [STEPS_W-1:0] in_steps;

  function automatic logic [ID_W-1:0] clamp_id(input logic [ID_W-1:0] id);
    clamp_id = (32'(id) < NODE_COUNT) ? id : '0;
  endfunction

  assign node_idx  = NW'(node_r);
  assign cur_idx   = NW'(cur_r);
  assign q_idx     = NW'(tbl_q);
  assign lvl_m1    = lvl_r - LW'(1);
  assign in_steps  = in_tdata[STEPS_LSB +: STEPS_W];
  assign prs_q_idx = node_idx;

  always_comb begin
    cmd_nxt       = cmd_r;
    node_nxt      = node_r;
    par_nxt       = par_r;
    hi_nxt        = hi_r;
    low_nxt       = low_r;
    cur_nxt       = cur_r;
    lvl_nxt       = lvl_r;
    row_nxt       = row_r;
    sweep_nxt     = sweep_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    tbl_we        = 1'b0;
    tbl_waddr     = {node_idx, lvl_r};
    tbl_wdata     = tbl_q;
    tbl_raddr     = {cur_idx, lvl_m1};
    prs_we        = 1'b0;
    prs_waddr     = node_idx;
    prs_wdata     = 1'b1;
    case (op)
      OP_CAPTURE: begin
        cmd_nxt  = in_tuser[CMD_W-1:0];
        node_nxt = clamp_id(in_tdata[NODE_LSB +: ID_W]);
        par_nxt  = clamp_id(in_tdata[PAR_LSB +: ID_W]);
        hi_nxt   = in_steps >> TOP;
        low_nxt  = in_steps << (STEPS_W - TOP);
      end
      OP_SWEEP: begin
        tbl_we    = 1'b1;
        tbl_waddr = sweep_r;
        tbl_wdata = '0;
        prs_we    = 1'b1;
        prs_waddr = sweep_r[AW-1:LW];
        prs_wdata = 1'b1;
        sweep_nxt = sweep_r + AW'(1);
      end
      OP_SET_PARENT: begin
        tbl_we    = 1'b1;
        tbl_waddr = {node_idx, LW'(0)};
        tbl_wdata = par_r;
        prs_we    = 1'b1;
        prs_wdata = 1'b1;
        cur_nxt   = par_r;
        lvl_nxt   = LW'(1);
      end
      OP_REMOVE: begin
        prs_we    = 1'b1;
        prs_wdata = 1'b0;
      end
      OP_BLD_INIT: begin
        lvl_nxt = LW'(1);
        row_nxt = NW'(1);
      end
      OP_RD_LVL: begin
        tbl_raddr = {cur_idx, lvl_m1};
      end
      OP_RD_ROW: begin
        tbl_raddr = {row_r, lvl_m1};
      end
      OP_RD_Q: begin
        tbl_raddr = {q_idx, lvl_m1};
      end
      OP_RD_TOP: begin
        tbl_raddr = {cur_idx, LVL_TOP};
      end
      OP_INS_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {node_idx, lvl_r};
        tbl_wdata = tbl_q;
        cur_nxt   = tbl_q;
        lvl_nxt   = lvl_r + LW'(1);
      end
      OP_BLD_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {row_r, lvl_r};
        tbl_wdata = tbl_q;
        if (row_r == ROW_LAST) begin
          row_nxt = NW'(1);
          lvl_nxt = lvl_r + LW'(1);
        end else begin
          row_nxt = row_r + NW'(1);
        end
      end
      OP_PRS_RD: begin
        cur_nxt = node_r;
        lvl_nxt = LVL_TOP;
      end
      OP_Q_ZERO: begin
        cur_nxt = '0;
      end
      OP_HI_TAKE: begin
        cur_nxt = tbl_q;
        hi_nxt  = hi_r - STEPS_W'(1);
      end
      OP_BIT_TAKE: begin
        cur_nxt = tbl_q;
        lvl_nxt = lvl_m1;
        low_nxt = low_r << 1;
      end
      OP_BIT_SKIP: begin
        lvl_nxt = lvl_m1;
        low_nxt = low_r << 1;
      end
      OP_OUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = cur_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    node_r     <= node_nxt;
    par_r      <= par_nxt;
    hi_r       <= hi_nxt;
    low_r      <= low_nxt;
    cur_r      <= cur_nxt;
    lvl_r      <= lvl_nxt;
    row_r      <= row_nxt;
    out_data_r <= out_data_nxt;
  end

  kla_ram #(
    .AW (AW),
    .DW (ID_W)
  ) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_q)
  );

  kla_ram #(
    .AW (NW),
    .DW (1)
  ) u_prs (
    .clk   (clk),
    .we    (prs_we),
    .waddr (prs_waddr),
    .wdata (prs_wdata),
    .raddr (prs_q_idx),
    .rdata (prs_q)
  );

  assign stat.cmd        = cmd_r;
  assign stat.node_zero  = (node_r == '0);
  assign stat.sweep_last = &sweep_r;
  assign stat.lvl_last   = (lvl_r == LVL_TOP);
  assign stat.row_last   = (row_r == ROW_LAST);
  assign stat.present    = prs_q;
  assign stat.cur_zero   = (cur_r == '0);
  assign stat.hi_zero    = (hi_r == '0);
  assign stat.lvl_zero   = (lvl_r == '0);
  assign stat.bit_set    = low_r[STEPS_W-1];
  assign stat.out_busy   = out_valid_r & ~out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

endmodule

>>> hw/rtl/kla_ctrl.sv
module kla_ctrl #(
  parameter int LEVELS = 20
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  kla_pkg::kla_stat_t stat,
  output kla_pkg::kla_op_t   op
);
  import kla_pkg::*;

  localparam logic ONE_LEVEL = (LEVELS == 1);

  localparam logic [3:0] S_SWEEP  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_DISP   = 4'd2;
  localparam logic [3:0] S_I_RD   = 4'd3;
  localparam logic [3:0] S_I_WR   = 4'd4;
  localparam logic [3:0] S_B1     = 4'd5;
  localparam logic [3:0] S_B2     = 4'd6;
  localparam logic [3:0] S_B3     = 4'd7;
  localparam logic [3:0] S_Q_CHK  = 4'd8;
  localparam logic [3:0] S_Q_SEL  = 4'd9;
  localparam logic [3:0] S_Q_HHOP = 4'd10;
  localparam logic [3:0] S_Q_BHOP = 4'd11;
  localparam logic [3:0] S_Q_OUT  = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NOP;
    in_tready = 1'b0;
    case (state_r)
      S_SWEEP: begin
        op = OP_SWEEP;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op        = OP_CAPTURE;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        state_nxt = S_IDLE;
        case (stat.cmd)
          CMD_LOAD: begin
            if (!stat.node_zero) begin
              op = OP_SET_PARENT;
            end
          end
          CMD_BUILD: begin
            if (!ONE_LEVEL) begin
              op        = OP_BLD_INIT;
              state_nxt = S_B1;
            end
          end
          CMD_INSERT: begin
            if (!stat.node_zero) begin
              op = OP_SET_PARENT;
              if (!ONE_LEVEL) begin
                state_nxt = S_I_RD;
              end
            end
          end
          CMD_REMOVE: begin
            if (!stat.node_zero) begin
              op = OP_REMOVE;
            end
          end
          CMD_QUERY: begin
            if (stat.node_zero) begin
              op        = OP_Q_ZERO;
              state_nxt = S_Q_OUT;
            end else begin
              op        = OP_PRS_RD;
              state_nxt = S_Q_CHK;
            end
          end
          CMD_CLEAR: begin
            state_nxt = S_SWEEP;
          end
          default: begin
          end
        endcase
      end
      S_I_RD: begin
        op        = OP_RD_LVL;
        state_nxt = S_I_WR;
      end
      S_I_WR: begin
        op        = OP_INS_WR;
        state_nxt = stat.lvl_last ? S_IDLE : S_I_RD;
      end
      S_B1: begin
        op        = OP_RD_ROW;
        state_nxt = S_B2;
      end
      S_B2: begin
        op        = OP_RD_Q;
        state_nxt = S_B3;
      end
      S_B3: begin
        op        = OP_BLD_WR;
        state_nxt = (stat.row_last && stat.lvl_last) ? S_IDLE : S_B1;
      end
      S_Q_CHK: begin
        if (stat.present) begin
          state_nxt = S_Q_SEL;
        end else begin
          op        = OP_Q_ZERO;
          state_nxt = S_Q_OUT;
        end
      end
      S_Q_SEL: begin
        if (stat.cur_zero) begin
          state_nxt = S_Q_OUT;
        end else if (!stat.hi_zero) begin
          op        = OP_RD_TOP;
          state_nxt = S_Q_HHOP;
        end else if (stat.lvl_zero) begin
          state_nxt = S_Q_OUT;
        end else if (stat.bit_set) begin
          op        = OP_RD_LVL;
          state_nxt = S_Q_BHOP;
        end else begin
          op = OP_BIT_SKIP;
        end
      end
      S_Q_HHOP: begin
        op        = OP_HI_TAKE;
        state_nxt = S_Q_SEL;
      end
      S_Q_BHOP: begin
        op        = OP_BIT_TAKE;
        state_nxt = S_Q_SEL;
      end
      S_Q_OUT: begin
        if (!stat.out_busy) begin
          op        = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/kth_ancestor_lifting_table.sv
// Binary-lifting k-th ancestor table for a forest of NODE_COUNT nodes, node 0 meaning none.
// Requests enter on the in_ stream: in_tuser carries the command (load, build, insert,
// remove, query, clear) and in_tdata carries node, parent and steps. Only a query
// request produces a result on the out_ stream, one ancestor id in out_tdata.
// One request is worked on at a time; in_tready is high only while the block is idle.
// Load and remove write straight from dispatch; insert fills its levels one after another and build
// every row of every level, each entry from dependent reads of the single read port of the table memory.
// A query checks the present flag, makes the top-level jumps, then one jump per set low bit of steps,
// ending early once the walk reaches node 0; the walk is one dependent table read after another.
// After reset, and after a clear request, a clearing pass writes every table entry
// and present flag while in_tready stays low.
// The result sits in an output register: while the receiver stalls, the block keeps taking
// requests, and a new query waits at its end until the previous result has been taken.
module kth_ancestor_lifting_table #(
  parameter int NODE_COUNT = kla_pkg::DEF_NODE_COUNT,
  parameter int LEVELS     = kla_pkg::DEF_LEVELS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // node[9:0], parent[19:10], steps[39:20]
  input  logic [kla_pkg::IN_TDATA_W-1:0]  in_tdata,
  // cmd[2:0], zero fill above
  input  logic [kla_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // ancestor[9:0], zero fill above
  output logic [kla_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import kla_pkg::*;

  kla_op_t   op;
  kla_stat_t stat;

  kla_ctrl #(
    .LEVELS (LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .op        (op)
  );

  kla_datapath #(
    .NODE_COUNT (NODE_COUNT),
    .LEVELS     (LEVELS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .op         (op),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> tb/sv/kth_ancestor_lifting_table_tb.sv
`timescale 1ns / 1ps

module kth_ancestor_lifting_table_tb;
  import kla_pkg::*;

  localparam int NODES = DEF_NODE_COUNT;
  localparam int LVLS = DEF_LEVELS;
  localparam int TOP = DEF_LEVELS - 1;
  localparam int IDLE_LIMIT = 200000;
  localparam int RANDOM_REQUESTS = 1025;

  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic [STEPS_W-1:0] steps;
    logic [ID_W-1:0]    parent;
    logic [ID_W-1:0]    node;
  } lift_req_t;

  typedef enum logic [1:0] {RX_EAGER, RX_COIN, RX_SPARSE, RX_STINGY} rx_mode_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  lift_req_t       pending_reqs[$];
  logic [ID_W-1:0] ancestor_due[$];
  logic [ID_W-1:0] lift_tab[NODES][LVLS];
  bit              alive[NODES];

  int total_reqs = 0;
  int accepted_reqs = 0;
  int answers_checked = 0;
  int fail_count = 0;
  int n_builds = 0;
  int n_inserts = 0;
  int n_clears = 0;
  int n_spare = 0;

  kth_ancestor_lifting_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic void wipe_forest();
    for (int n = 0; n < NODES; n++) begin
      alive[n] = 1'b1;
      for (int l = 0; l < LVLS; l++) begin
        lift_tab[n][l] = '0;
      end
    end
  endfunction

  function automatic logic [ID_W-1:0] fit_id(logic [ID_W-1:0] v);
    return (int'(v) < NODES) ? v : '0;
  endfunction

  function automatic void advance_forest(lift_req_t r);
    logic [ID_W-1:0] n;
    logic [ID_W-1:0] p;
    logic [ID_W-1:0] cur;
    int              hi;
    n = fit_id(r.node);
    p = fit_id(r.parent);
    case (r.cmd)
      CMD_LOAD: begin
        if (n != 0) begin
          lift_tab[n][0] = p;
          alive[n] = 1'b1;
        end
      end
      CMD_BUILD: begin
        n_builds++;
        for (int l = 1; l < LVLS; l++) begin
          for (int m = 1; m < NODES; m++) begin
            lift_tab[m][l] = lift_tab[lift_tab[m][l-1]][l-1];
          end
        end
      end
      CMD_INSERT: begin
        n_inserts++;
        if (n != 0) begin
          lift_tab[n][0] = p;
          for (int l = 1; l < LVLS; l++) begin
            lift_tab[n][l] = lift_tab[lift_tab[n][l-1]][l-1];
          end
          alive[n] = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (n != 0) alive[n] = 1'b0;
      end
      CMD_QUERY: begin
        cur = '0;
        if (n != 0 && alive[n]) begin
          // Bits of k at and above the top level count as repeated top-level jumps.
          cur = n;
          hi = int'(r.steps >> TOP);
          while (hi != 0 && cur != 0) begin
            cur = lift_tab[cur][TOP];
            hi--;
          end
          for (int b = TOP - 1; b >= 0; b--) begin
            if (r.steps[b]) cur = lift_tab[cur][b];
          end
        end
        ancestor_due = {ancestor_due, cur};
      end
      CMD_CLEAR: begin
        n_clears++;
        wipe_forest();
      end
      default: begin
        n_spare++;
      end
    endcase
  endfunction

  function automatic void queue_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] node,
                                        logic [ID_W-1:0] parent, logic [STEPS_W-1:0] steps);
    lift_req_t r;
    r.cmd = cmd;
    r.node = node;
    r.parent = parent;
    r.steps = steps;
    pending_reqs = {pending_reqs, r};
    total_reqs++;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    lift_req_t r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tuser <= '0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0 || pending_reqs.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        r = pending_reqs.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= {r.steps, r.parent, r.node};
        in_tuser <= {{(IN_TUSER_W-CMD_W){1'b0}}, r.cmd};
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end
    end
  end

  // Result receiver: the stall pattern changes mode at random intervals.
  rx_mode_t rx_mode = RX_EAGER;
  int       rx_mode_left = 0;
  int       rx_tick = 0;

  always @(posedge clk) begin
    logic rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(32, 256);
      end else begin
        rx_mode_left--;
      end
      case (rx_mode)
        RX_EAGER:  rdy = 1'b1;
        RX_COIN:   rdy = 1'($urandom_range(0, 1));
        RX_SPARSE: rdy = (rx_tick % 7 == 0);
        default:   rdy = ($urandom_range(0, 15) == 0);
      endcase
      out_tready <= rdy;
    end
  end

  // Monitor: checks results against the oldest prediction, then updates the forest.
  always @(posedge clk) begin
    logic [ID_W-1:0] want;
    if (!rst_n) begin
      wipe_forest();
      ancestor_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (ancestor_due.size() == 0) begin
          $error("unexpected result: ancestor %0d", out_tdata[ID_W-1:0]);
          fail_count++;
        end else begin
          want = ancestor_due.pop_front();
          answers_checked++;
          if (out_tdata[ID_W-1:0] !== want) begin
            $error("ancestor mismatch: expected %0d, actual %0d", want, out_tdata[ID_W-1:0]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        advance_forest(lift_req_t'({in_tuser[CMD_W-1:0], in_tdata}));
        accepted_reqs++;
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("kth_ancestor_lifting_table regression: fail");
        $finish;
      end
    end
  end

  initial begin
    logic [ID_W-1:0]    tip;
    logic [ID_W-1:0]    nd;
    logic [ID_W-1:0]    par;
    logic [STEPS_W-1:0] k;
    logic [ID_W-1:0]    touched[$];
    int                 depth;
    int                 sel;
    int                 builds_left;
    int                 clears_left;

    // A chain 1023 -> 4 -> 3 -> 2 -> 1, walked after build, insert and remove.
    queue_request(CMD_QUERY, 10'd5, 10'd0, 20'd0);
    queue_request(CMD_QUERY, 10'd0, 10'd1023, 20'hFFFFF);
    queue_request(CMD_LOAD, 10'd2, 10'd1, 20'd0);
    queue_request(CMD_LOAD, 10'd3, 10'd2, 20'd0);
    queue_request(CMD_LOAD, 10'd4, 10'd3, 20'd0);
    queue_request(CMD_LOAD, 10'd1023, 10'd4, 20'd0);
    queue_request(CMD_LOAD, 10'd0, 10'd5, 20'd0);
    queue_request(CMD_BUILD, 10'd0, 10'd0, 20'd0);
    queue_request(CMD_QUERY, 10'd1023, 10'd0, 20'd3);
    queue_request(CMD_QUERY, 10'd1023, 10'd0, 20'd5);
    queue_request(CMD_QUERY, 10'd1023, 10'd0, 20'hFFFFF);
    queue_request(CMD_INSERT, 10'd1000, 10'd1023, 20'd0);
    queue_request(CMD_QUERY, 10'd1000, 10'd0, 20'd4);
    queue_request(CMD_INSERT, 10'd0, 10'd3, 20'd0);
    queue_request(CMD_REMOVE, 10'd3, 10'd0, 20'd0);
    queue_request(CMD_QUERY, 10'd3, 10'd0, 20'd0);
    queue_request(CMD_QUERY, 10'd1000, 10'd0, 20'd4);
    queue_request(CMD_REMOVE, 10'd0, 10'd0, 20'd0);
    // A node that is its own parent keeps a nonzero top level, so the top jump matters.
    queue_request(CMD_INSERT, 10'd7, 10'd7, 20'd0);
    queue_request(CMD_QUERY, 10'd7, 10'd0, 20'hFFFFF);
    queue_request(CMD_SPARE_LO, ID_W'($urandom), ID_W'($urandom), STEPS_W'($urandom));
    queue_request(CMD_SPARE_HI, ID_W'($urandom), ID_W'($urandom), STEPS_W'($urandom));
    queue_request(CMD_QUERY, 10'd1023, 10'd1023, 20'd0);
    queue_request(CMD_CLEAR, 10'd0, 10'd0, 20'd0);
    queue_request(CMD_QUERY, 10'd1023, 10'd0, 20'd1);

    // Random part: mostly grows chains of inserts and queries near their depth.
    tip = '0;
    depth = 0;
    builds_left = 3;
    clears_left = 2;
    for (int i = 0; i < RANDOM_REQUESTS; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 28 || (sel >= 58 && sel < 72)) begin
        nd = ($urandom_range(0, 49) == 0) ? '0 : ID_W'($urandom_range(1, NODES - 1));
        case ($urandom_range(0, 9))
          0:       par = '0;
          1:       par = nd;
          2, 3:    par = ID_W'($urandom);
          default: par = tip;
        endcase
        if (par == tip && nd != 0) begin
          tip = nd;
          depth++;
        end
        if ($urandom_range(0, 39) == 0) begin
          tip = ID_W'($urandom);
          depth = 0;
        end
        if (nd != 0) touched = {touched, nd};
        if (touched.size() > 64) void'(touched.pop_front());
        queue_request((sel < 28) ? CMD_INSERT : CMD_LOAD, nd, par, STEPS_W'($urandom));
      end else if (sel >= 72 && sel < 78) begin
        nd = (touched.size() != 0) ? touched[$urandom_range(0, touched.size() - 1)]
                                   : ID_W'($urandom);
        queue_request(CMD_REMOVE, nd, ID_W'($urandom), STEPS_W'($urandom));
      end else if (sel >= 78 && sel < 80 && builds_left > 0) begin
        builds_left--;
        queue_request(CMD_BUILD, ID_W'($urandom), ID_W'($urandom), STEPS_W'($urandom));
      end else if (sel == 80 && clears_left > 0) begin
        clears_left--;
        tip = '0;
        depth = 0;
        touched.delete();
        queue_request(CMD_CLEAR, ID_W'($urandom), ID_W'($urandom), STEPS_W'($urandom));
      end else if (sel >= 81 && sel < 83) begin
        queue_request(($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI,
                      ID_W'($urandom), ID_W'($urandom), STEPS_W'($urandom));
      end else begin
        case ($urandom_range(0, 3))
          0:       nd = ID_W'($urandom);
          1:       nd = tip;
          default: nd = (touched.size() != 0) ? touched[$urandom_range(0, touched.size() - 1)]
                                              : tip;
        endcase
        case ($urandom_range(0, 9))
          0:       k = '0;
          1:       k = STEPS_W'($urandom);
          2:       k = (STEPS_W'(1) << TOP) | STEPS_W'($urandom_range(0, depth + 2));
          3:       k = STEPS_W'(1) << $urandom_range(0, STEPS_W - 1);
          default: k = STEPS_W'($urandom_range(0, depth + 2));
        endcase
        queue_request(CMD_QUERY, nd, ID_W'($urandom), k);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (accepted_reqs != total_reqs) @(posedge clk);
    while (ancestor_due.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("%0d requests sent, %0d query answers checked", accepted_reqs, answers_checked);
    $display("%0d builds, %0d inserts, %0d clears, %0d unused commands",
             n_builds, n_inserts, n_clears, n_spare);
    if (fail_count == 0) begin
      $display("kth_ancestor_lifting_table regression: pass");
    end else begin
      $display("kth_ancestor_lifting_table regression: fail");
    end
    $finish;
  end

endmodule
